@@ sv/bhtq_pkg.sv @@
// Package for the binary heap timer queue: sizes, codes and word types.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package bhtq_pkg;
    localparam int CAPACITY  = 64;
    localparam int TIMER_IDS = 256;
    localparam int PW        = $clog2(CAPACITY + 1);
    localparam int SW        = $clog2(CAPACITY);
    localparam int IW        = $clog2(TIMER_IDS);
    localparam logic [31:0] EMPTY_WAIT_RST = 32'd100000;

    typedef enum logic [1:0] {
        F_INSERT = 2'd0,
        F_REMOVE = 2'd1,
        F_RUN    = 2'd2,
        F_PEEK   = 2'd3
    } t_func;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  timer_id;
        logic [31:0] wake_ms;
        logic [31:0] now;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic        fired;
        logic [7:0]  expired_id;
        logic [6:0]  heap_position;
        logic [31:0] time_value;
        logic        last;
    } t_out_word;

    typedef struct packed {
        logic [IW-1:0] id;
        logic [31:0]   t;
    } t_entry;
endpackage

@@ sv/bhtq_if.sv @@
// Valid/ready channel interfaces carrying one input or one result word.
// Depends on bhtq_pkg.
`timescale 1ns / 1ps

interface bhtq_in_if import bhtq_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bhtq_out_if import bhtq_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/binary_heap_timer_queue_core.sv @@
// Top level of the binary heap timer queue: sequencer, heap memory and
// position table. Depends on bhtq_pkg and the interfaces in bhtq_if.
`timescale 1ns / 1ps

// Channel   Direction  Handshake     Content
// in        sink       valid/ready   func, timer_id, wake_ms, now
// out       source     valid/ready   status, fired, expired_id, heap_position,
//                                    time_value, last
// cfg       write      i_cfg_we      empty_wait
//
// One word is worked at a time. The heap lives in a single-port memory with
// a registered read; a sift level going up reads the parent, waits, then
// compares and writes, and going down reads the children, picks the smaller,
// then compares and writes. Each expired timer is reported one pop late, so
// that the last one can carry the wait. After reset a clearing pass zeroes
// the position table, during which no input word is accepted. Result words
// are held in an output register; a stalled output simply holds the sequencer.
module binary_heap_timer_queue_core
    import bhtq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    bhtq_in_if.sink     in_ch,
    bhtq_out_if.source  out_ch
);
    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_POS_RD, S_POS_WT, S_DISPATCH,
        S_UP_RD, S_UP_WT, S_UP_CMP,
        S_DN_RD1, S_DN_RD2, S_DN_WT, S_DN_CMP,
        S_PLACE, S_LAST_RD, S_LAST_WT, S_REMOVE,
        S_RUN_RD, S_RUN_WT, S_RUN_CHK, S_EMIT, S_PEEK_RD, S_PEEK_WT
    } t_state;

    t_state r_state;
    logic [31:0] r_empty_wait;

    // Heap memory, slot 1..CAPACITY stored at address slot-1.
    t_entry r_heap [CAPACITY];
    t_entry r_heap_q;
    logic [SW-1:0] heap_addr;
    logic          heap_we;
    t_entry        heap_wd;

    // Position table, value 0 means absent.
    logic [PW-1:0] r_pos [TIMER_IDS];
    logic [PW-1:0] r_pos_q;
    logic [IW-1:0] pos_addr;
    logic          pos_we;
    logic [PW-1:0] pos_wd;

    // A result word that reports no expired timer.
    function automatic t_out_word result_word(input logic [1:0] st,
                                              input logic [PW-1:0] pos,
                                              input logic [31:0] tv);
        t_out_word w;
        w.status        = st;
        w.fired         = 1'b0;
        w.expired_id    = 8'd0;
        w.heap_position = 7'(pos);
        w.time_value    = tv;
        w.last          = 1'b1;
        return w;
    endfunction

    // A result word that reports an expired timer.
    function automatic t_out_word fired_word(input logic [IW-1:0] id,
                                             input logic lst,
                                             input logic [31:0] tv);
        t_out_word w;
        w.status        = ST_OK;
        w.fired         = 1'b1;
        w.expired_id    = 8'(id);
        w.heap_position = 7'd0;
        w.time_value    = tv;
        w.last          = lst;
        return w;
    endfunction

    always_ff @(posedge i_clk) begin
        if (heap_we) begin
            r_heap[heap_addr] <= heap_wd;
        end
        r_heap_q <= r_heap[heap_addr];
    end

    always_ff @(posedge i_clk) begin
        if (pos_we) begin
            r_pos[pos_addr] <= pos_wd;
        end
        r_pos_q <= r_pos[pos_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_empty_wait <= EMPTY_WAIT_RST;
        end else if (i_cfg_we) begin
            r_empty_wait <= i_cfg_data;
        end
    end

    t_in_word      r_in;
    logic [PW-1:0] r_count;
    logic [PW-1:0] r_i;      // hole slot
    logic [PW:0]   r_j;      // child slot under test
    t_entry        r_key;    // entry being sifted
    t_entry        r_a;      // first child / parent read
    logic [IW-1:0] r_clr;
    logic          r_fired_any;
    logic          r_ovalid;
    t_out_word     r_out;
    logic          r_is_run;
    logic [IW-1:0] r_fid;    // timer being removed, also the last one popped

    // Memory access decode.
    always_comb begin
        heap_addr = '0;
        heap_we   = 1'b0;
        heap_wd   = r_key;
        pos_addr  = r_in.timer_id[IW-1:0];
        pos_we    = 1'b0;
        pos_wd    = '0;
        case (r_state)
            S_CLEAR: begin
                pos_addr = r_clr;
                pos_we   = 1'b1;
            end
            S_UP_RD:   heap_addr = SW'((r_i >> 1) - PW'(1));
            S_DN_RD1:  heap_addr = SW'(r_j - (PW+1)'(1));
            S_DN_RD2:  heap_addr = SW'(r_j);
            S_LAST_RD: heap_addr = SW'(r_count - PW'(1));
            S_RUN_RD, S_PEEK_RD: heap_addr = '0;
            S_UP_CMP: begin
                if (r_a.t > r_key.t) begin
                    heap_addr = SW'(r_i - PW'(1));
                    heap_we   = 1'b1;
                    heap_wd   = r_a;
                    pos_addr  = r_a.id;
                    pos_we    = 1'b1;
                    pos_wd    = r_i;
                end
            end
            S_DN_CMP: begin
                if (r_key.t > r_a.t) begin
                    heap_addr = SW'(r_i - PW'(1));
                    heap_we   = 1'b1;
                    heap_wd   = r_a;
                    pos_addr  = r_a.id;
                    pos_we    = 1'b1;
                    pos_wd    = r_i;
                end
            end
            S_PLACE: begin
                heap_addr = SW'(r_i - PW'(1));
                heap_we   = 1'b1;
                heap_wd   = r_key;
                pos_addr  = r_key.id;
                pos_we    = 1'b1;
                pos_wd    = r_i;
            end
            S_REMOVE: begin
                pos_addr = r_fid;
                pos_we   = 1'b1;
                pos_wd   = '0;
            end
            default: ;
        endcase
    end

    logic [32:0] wait_d;
    logic [31:0] run_wait;
    assign wait_d   = {1'b0, r_heap_q.t} - {1'b0, r_in.now} + 33'd1;
    assign run_wait = (r_count == '0) ? r_empty_wait :
                      (wait_d[32] ? 32'hFFFF_FFFF : wait_d[31:0]);

    assign in_ch.ready  = (r_state == S_IDLE) && !r_ovalid;
    assign out_ch.valid = r_ovalid;
    assign out_ch.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && out_ch.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + IW'(1);
                    if (r_clr == IW'(TIMER_IDS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_ch.valid && in_ch.ready) begin
                        r_in        <= in_ch.data;
                        r_fired_any <= 1'b0;
                        r_is_run    <= 1'b0;
                        r_state     <= S_POS_RD;
                    end
                end
                S_POS_RD: r_state <= S_POS_WT;
                S_POS_WT: r_state <= S_DISPATCH;
                S_DISPATCH: begin
                    case (r_in.func)
                        F_INSERT: begin
                            r_key <= '{id: r_in.timer_id[IW-1:0], t: r_in.wake_ms};
                            if (r_pos_q == '0 || r_pos_q > r_count) begin
                                if (r_count == PW'(CAPACITY)) begin
                                    r_out    <= result_word(ST_FULL, '0, 32'd0);
                                    r_ovalid <= 1'b1;
                                    r_state  <= S_IDLE;
                                end else begin
                                    r_count <= r_count + PW'(1);
                                    r_i     <= r_count + PW'(1);
                                    r_state <= S_UP_RD;
                                end
                            end else begin
                                r_i     <= r_pos_q;
                                r_state <= S_UP_RD;
                            end
                        end
                        F_REMOVE: begin
                            if (r_pos_q == '0 || r_pos_q > r_count) begin
                                r_out    <= result_word(ST_ABSENT, '0, 32'd0);
                                r_ovalid <= 1'b1;
                                r_state  <= S_IDLE;
                            end else begin
                                r_i     <= r_pos_q;
                                r_fid   <= r_in.timer_id[IW-1:0];
                                r_state <= S_REMOVE;
                            end
                        end
                        F_RUN: begin
                            r_is_run <= 1'b1;
                            r_state  <= S_RUN_RD;
                        end
                        default: r_state <= S_PEEK_RD;
                    endcase
                end
                // Sift up: move larger parents down into the hole.
                S_UP_RD: begin
                    if (r_i > PW'(1)) begin
                        r_state <= S_UP_WT;
                    end else begin
                        r_j     <= {r_i, 1'b0};
                        r_state <= S_DN_RD1;
                    end
                end
                S_UP_WT: begin
                    r_a     <= r_heap_q;
                    r_state <= S_UP_CMP;
                end
                S_UP_CMP: begin
                    if (r_a.t > r_key.t) begin
                        r_i     <= r_i >> 1;
                        r_state <= S_UP_RD;
                    end else begin
                        r_j     <= {r_i, 1'b0};
                        r_state <= S_DN_RD1;
                    end
                end
                // Sift down: pick the smaller child, move it up if needed.
                S_DN_RD1: begin
                    r_state <= (r_j <= {1'b0, r_count}) ? S_DN_RD2 : S_PLACE;
                end
                S_DN_RD2: begin
                    r_a <= r_heap_q;
                    r_state <= (r_j < {1'b0, r_count}) ? S_DN_WT : S_DN_CMP;
                end
                S_DN_WT: begin
                    if (r_a.t > r_heap_q.t) begin
                        r_a <= r_heap_q;
                        r_j <= r_j + (PW+1)'(1);
                    end
                    r_state <= S_DN_CMP;
                end
                S_DN_CMP: begin
                    if (r_key.t > r_a.t) begin
                        r_i     <= PW'(r_j);
                        r_j     <= {r_j[PW-1:0], 1'b0};
                        r_state <= S_DN_RD1;
                    end else begin
                        r_state <= S_PLACE;
                    end
                end
                S_PLACE: begin
                    if (r_is_run) begin
                        r_state <= S_RUN_RD;
                    end else begin
                        r_out <= result_word(ST_OK,
                                             (r_in.func == F_INSERT) ? r_i : PW'(0),
                                             32'd0);
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                // Remove r_fid at slot r_i: clear its position, refill hole.
                S_REMOVE: begin
                    r_state <= S_LAST_RD;
                end
                S_LAST_RD: r_state <= S_LAST_WT;
                S_LAST_WT: begin
                    r_key   <= r_heap_q;
                    r_count <= r_count - PW'(1);
                    if (r_i <= r_count - PW'(1)) begin
                        r_state <= S_UP_RD;
                    end else if (r_is_run) begin
                        r_state <= S_RUN_RD;
                    end else begin
                        // The removed timer sat in the last slot; no sift.
                        r_out    <= result_word(ST_OK, '0, 32'd0);
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                // The output register is free before the check goes on.
                S_RUN_RD: begin
                    if (!r_ovalid || out_ch.ready) begin
                        r_state <= S_RUN_WT;
                    end
                end
                S_RUN_WT: r_state <= S_RUN_CHK;
                S_RUN_CHK: begin
                    if (r_count != '0 && r_heap_q.t <= r_in.now) begin
                        // The timer popped before this one goes out now.
                        if (r_fired_any) begin
                            r_out    <= fired_word(r_fid, 1'b0, 32'd0);
                            r_ovalid <= 1'b1;
                        end
                        r_fired_any <= 1'b1;
                        r_fid   <= r_heap_q.id;
                        r_i     <= PW'(1);
                        r_state <= S_EMIT;
                    end else begin
                        if (r_fired_any) begin
                            r_out <= fired_word(r_fid, 1'b1, run_wait);
                        end else begin
                            r_out <= result_word(ST_OK, '0, run_wait);
                        end
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                // A spare state before the removal of the popped timer.
                S_EMIT: begin
                    r_state <= S_REMOVE;
                end
                S_PEEK_RD: r_state <= S_PEEK_WT;
                S_PEEK_WT: begin
                    r_out <= result_word(ST_OK, '0,
                                         (r_count == '0) ? 32'd0 : r_heap_q.t);
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
